/* sv/vrmd_pkg.sv */
// Shared widths, stream word layouts and queue sizing for the viseme run merge block.
`timescale 1ns / 1ps

package vrmd_pkg;

    // Field widths of one mark on the stream ports
    localparam int CODE_W = 4;
    localparam int TIME_W = 32;
    localparam int CONF_W = 8;
    localparam int MIN_W  = 16;
    localparam int PAD_W  = 4;
    localparam int DATA_W = CODE_W + 2 * TIME_W + CONF_W + PAD_W;

    // Result queue: one transaction in can produce up to three results
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = 3;
    localparam int QCNT_W      = 4;
    localparam int MAX_BURST   = 3;

    // tdata layout, lowest field first: code, start, end, confidence, zero pad
    typedef struct packed {
        logic [PAD_W-1:0]  pad;
        logic [CONF_W-1:0] conf;
        logic [TIME_W-1:0] stop;
        logic [TIME_W-1:0] start;
        logic [CODE_W-1:0] code;
    } mark_word_t;

    // One queued result: stream word plus its tlast
    typedef struct packed {
        logic       last;
        mark_word_t word;
    } result_t;

endpackage

/* sv/viseme_run_merge_debounce.sv */
// Viseme mark run merge and minimum-duration debounce, with result queue.
`timescale 1ns / 1ps

// Path: a mark is accepted into the input register and decoded there; its results go into the
//   queue, and the output register takes them from it. Throughput: one mark per cycle, set by
//   the single-pass merge/debounce logic after the input register; the 8-entry queue drains
//   one result per cycle into the output register unless m_tready holds it, and a mark waits
//   in the input register while the queue has fewer than three free entries.
// Reset: all valid flags, the queue pointers and count and min_duration_ms clear to zero; marks are lost.
module viseme_run_merge_debounce #(
    parameter int TIME_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration: min_duration_ms
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [vrmd_pkg::MIN_W-1:0]  cfg_data,
    // Input marks
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tdata: viseme_code[3:0], onset_ms[35:4], end_ms[67:36], confidence[75:68], zero[79:76]
    input  logic [vrmd_pkg::DATA_W-1:0] s_tdata,
    input  logic                        s_tlast,   // last_item
    // Output marks
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata: out_viseme[3:0], out_onset_ms[35:4], out_end_ms[67:36],
    //          out_confidence[75:68], zero[79:76]
    output logic [vrmd_pkg::DATA_W-1:0] m_tdata,
    output logic                        m_tlast    // last_mark
);

    localparam int TW = vrmd_pkg::TIME_W;
    localparam int CW = vrmd_pkg::CONF_W;

    typedef struct packed {
        logic [vrmd_pkg::CODE_W-1:0] code;
        logic [TIME_BITS-1:0]        start;
        logic [TIME_BITS-1:0]        stop;
        logic [CW-1:0]               conf;
    } mark_t;

    typedef struct packed {
        logic                 held_v;
        mark_t                held;
        logic                 carry_v;
        logic [TIME_BITS-1:0] carry;
    } smooth_t;

    typedef struct packed {
        smooth_t st;
        logic    emit;
        mark_t   out;
    } s2_res_t;

    // Debounce one closed mark against the held mark and carried start
    function automatic s2_res_t stage_two(input smooth_t s, input mark_t m_in, input logic fin,
                                          input logic [vrmd_pkg::MIN_W-1:0] min_dur);
        s2_res_t            res;
        mark_t              m;
        logic               long_ok;
        logic [TIME_BITS:0] pad;
        res      = '{st: s, emit: 1'b0, out: s.held};
        m        = m_in;
        if (s.carry_v)
        begin
            m.start        = s.carry;
            res.st.carry_v = 1'b0;
        end
        long_ok = (m.stop >= m.start) && ((m.stop - m.start) >= TIME_BITS'(min_dur));
        pad     = {1'b0, m.start} + (TIME_BITS+1)'(min_dur);
        if (long_ok)
        begin
            res.emit      = s.held_v;
            res.st.held   = m;
            res.st.held_v = 1'b1;
        end
        else if (s.held_v)
        begin
            res.st.held.stop = m.stop;
        end
        else if (!fin)
        begin
            res.st.carry   = m.start;
            res.st.carry_v = 1'b1;
        end
        else
        begin
            m.stop        = pad[TIME_BITS] ? '1 : pad[TIME_BITS-1:0];
            res.st.held   = m;
            res.st.held_v = 1'b1;
        end
        return res;
    endfunction

    // Pack a mark into the stream word
    function automatic vrmd_pkg::result_t to_result(input mark_t m, input logic last);
        vrmd_pkg::result_t r;
        r.last       = last;
        r.word.pad   = '0;
        r.word.conf  = m.conf;
        r.word.stop  = TW'(m.stop);
        r.word.start = TW'(m.start);
        r.word.code  = m.code;
        return r;
    endfunction

    // Configuration register
    logic [vrmd_pkg::MIN_W-1:0] min_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_reg <= '0;
        else if (cfg_valid)
            min_reg <= cfg_data;
    end

    // Input register
    logic                        in_valid_reg, in_valid_next;
    logic [vrmd_pkg::DATA_W-1:0] in_data_reg;
    logic                        in_last_reg;
    logic                        consume;
    logic [vrmd_pkg::QCNT_W-1:0] count_reg, count_next;

    assign consume       = in_valid_reg &&
                           (count_reg <= vrmd_pkg::QCNT_W'(vrmd_pkg::QUEUE_DEPTH
                                                           - vrmd_pkg::MAX_BURST));
    assign s_tready      = !in_valid_reg || consume;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !consume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Merge and debounce state
    logic    pv_reg, pv_next;
    mark_t   pend_reg, pend_next;
    smooth_t sm_reg, sm_next;

    vrmd_pkg::mark_word_t in_word;
    mark_t                r_mark;
    logic                 merge;
    logic [CW:0]          conf_sum;
    mark_t                pend_new;
    smooth_t              st0, st_a;
    s2_res_t              res_a, res_b;
    logic                 close_a;
    logic                 emit_a, emit_b, emit_f;

    always_comb
    begin
        in_word      = vrmd_pkg::mark_word_t'(in_data_reg);
        r_mark.code  = in_word.code;
        r_mark.start = TIME_BITS'(in_word.start);
        r_mark.stop  = TIME_BITS'(in_word.stop);
        r_mark.conf  = in_word.conf;

        // Stage one: merge into the open mark or close it
        merge    = pv_reg && (pend_reg.code == r_mark.code) && (pend_reg.stop >= r_mark.start);
        conf_sum = (CW+1)'(pend_reg.conf) + (CW+1)'(r_mark.conf);
        pend_new = r_mark;
        if (merge)
        begin
            pend_new      = pend_reg;
            pend_new.conf = conf_sum[CW:1];
            if (r_mark.stop > pend_reg.stop)
                pend_new.stop = r_mark.stop;
        end

        // Stage two on the closed mark
        st0     = sm_reg;
        close_a = pv_reg && !merge;
        res_a   = stage_two(st0, pend_reg, 1'b0, min_reg);
        st_a    = close_a ? res_a.st : st0;
        emit_a  = consume && close_a && res_a.emit;

        // Flush: close the open mark as final, then release the held mark
        res_b   = stage_two(st_a, pend_new, 1'b1, min_reg);
        emit_b  = consume && in_last_reg && res_b.emit;
        emit_f  = consume && in_last_reg && res_b.st.held_v;

        // Advance state
        pv_next   = pv_reg;
        pend_next = pend_reg;
        sm_next   = sm_reg;
        if (consume)
        begin
            pend_next = pend_new;
            if (in_last_reg)
            begin
                pv_next         = 1'b0;
                sm_next         = res_b.st;
                sm_next.held_v  = 1'b0;
                sm_next.carry_v = 1'b0;
            end
            else
            begin
                pv_next = 1'b1;
                sm_next = st_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            sm_reg <= '0;
        end
        else
        begin
            pv_reg <= pv_next;
            sm_reg <= sm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    // Result queue with a registered output stage
    vrmd_pkg::result_t           queue_mem [vrmd_pkg::QUEUE_DEPTH];
    logic [vrmd_pkg::QPTR_W-1:0] head_reg, head_next;
    logic [vrmd_pkg::QPTR_W-1:0] tail_reg, tail_next;
    logic [vrmd_pkg::QPTR_W-1:0] ptr_b, ptr_f;
    logic [vrmd_pkg::QCNT_W-1:0] wr_cnt;
    logic                        pop;
    logic                        out_valid_reg, out_valid_next;
    vrmd_pkg::result_t           out_reg;

    always_comb
    begin
        ptr_b          = tail_reg + vrmd_pkg::QPTR_W'(emit_a);
        ptr_f          = ptr_b + vrmd_pkg::QPTR_W'(emit_b);
        wr_cnt         = vrmd_pkg::QCNT_W'(emit_a) + vrmd_pkg::QCNT_W'(emit_b)
                       + vrmd_pkg::QCNT_W'(emit_f);
        pop            = (count_reg != '0) && (!out_valid_reg || m_tready);
        out_valid_next = pop || (out_valid_reg && !m_tready);
        head_next      = head_reg + vrmd_pkg::QPTR_W'(pop);
        tail_next      = tail_reg + wr_cnt[vrmd_pkg::QPTR_W-1:0];
        count_next     = count_reg + wr_cnt - vrmd_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Write up to three results in order
    always_ff @(posedge clk)
    begin
        if (emit_a)
            queue_mem[tail_reg] <= to_result(res_a.out, 1'b0);
        if (emit_b)
            queue_mem[ptr_b] <= to_result(res_b.out, 1'b0);
        if (emit_f)
            queue_mem[ptr_f] <= to_result(res_b.st.held, 1'b1);
    end

    // Move the oldest queued result into the output register
    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= queue_mem[head_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.word;
    assign m_tlast  = out_reg.last;

    // Checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= vrmd_pkg::QCNT_W'(vrmd_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_flush_emits: assert property (@(posedge clk) disable iff (!rst_n)
        consume && in_last_reg |-> emit_f)
        else $error("flush produced no final result");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        consume && in_last_reg |=> !pv_reg && !sm_reg.held_v && !sm_reg.carry_v)
        else $error("state not cleared after flush");

    a_carry_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(sm_reg.held_v && sm_reg.carry_v))
        else $error("carried start alongside held mark");

endmodule
